### sv/ppt_pkg.sv
// Shared types and constants for the perspective point transform.
// No dependencies; used by every module of the block.
package ppt_pkg;

  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int QUO_W     = 32;
  localparam int NUM_W     = SUM_W + 16;
  localparam int REM_W     = SUM_W + QUO_W;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 8;
  localparam int REG_W     = 64;

  // sum stages + setup + range check + quotient bits + result stage
  localparam int SUM_LAT   = 3;
  localparam int DIV_LAT   = QUO_W + 3;
  localparam int LATENCY   = SUM_LAT + DIV_LAT;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      w_was_zero;
    logic                      saturated;
  } out_item_t;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic signed [SUM_W-1:0] sw;
  } sums_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] w;
  } sum_beat_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] value;
    logic                      sat;
    logic                      wzero;
  } comp_beat_t;

endpackage

### sv/ppt_sum.sv
// Row-vector times 4x4 matrix: twelve 32x32 products, then a two-level adder.
// Three register stages. Depends on ppt_pkg.
module ppt_sum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ppt_pkg::in_item_t in_item,
  input  ppt_pkg::matrix_t  mat,
  output ppt_pkg::sums_t    sums
);

  function automatic logic signed [ppt_pkg::COORD_W-1:0] coef(
    input ppt_pkg::matrix_t m, input int r, input int c);
    logic [ppt_pkg::REG_W-1:0] word;
    word = m[r * 2 + (c >> 1)];
    return (c % 2 == 1) ? word[63:32] : word[31:0];
  endfunction

  logic signed [ppt_pkg::COORD_W-1:0] pt [3];
  logic signed [ppt_pkg::PROD_W-1:0]  prod_r [3][4];
  logic signed [ppt_pkg::COORD_W-1:0] m3_r [4];
  logic signed [ppt_pkg::PROD_W:0]    a_r [4];
  logic signed [ppt_pkg::PROD_W:0]    b_r [4];
  logic signed [ppt_pkg::SUM_W-1:0]   s_r [4];
  logic                               v1_r, v2_r, v3_r;

  assign pt[0] = in_item.in_x;
  assign pt[1] = in_item.in_y;
  assign pt[2] = in_item.in_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][c] <= pt[r] * coef(mat, r, c);
      end
      m3_r[c] <= coef(mat, 3, c);
      a_r[c]  <= (ppt_pkg::PROD_W+1)'(prod_r[0][c]) + (ppt_pkg::PROD_W+1)'(prod_r[1][c]);
      // translation row is scaled to Q32.32 like the products
      b_r[c]  <= (ppt_pkg::PROD_W+1)'(prod_r[2][c])
               + (ppt_pkg::PROD_W+1)'($signed({m3_r[c], 16'h0000}));
      s_r[c]  <= ppt_pkg::SUM_W'(a_r[c]) + ppt_pkg::SUM_W'(b_r[c]);
    end
  end

  assign sums.valid = v3_r;
  assign sums.sx    = s_r[0];
  assign sums.sy    = s_r[1];
  assign sums.sz    = s_r[2];
  assign sums.sw    = s_r[3];

endmodule

### sv/ppt_div.sv
// One component: perspective divide as a restoring divider, one quotient
// bit per stage, plus the zero-w shift path and 32-bit saturation. Depends on ppt_pkg.
module ppt_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ppt_pkg::sum_beat_t  in_beat,
  output ppt_pkg::comp_beat_t out_beat
);

  localparam int SW  = ppt_pkg::SUM_W;
  localparam int RW  = ppt_pkg::REM_W;
  localparam int QW  = ppt_pkg::QUO_W;
  localparam int CW  = ppt_pkg::COORD_W;
  localparam int SHW = SW - 16;

  // setup stage
  logic [SW-1:0]          smag, wmag;
  logic signed [SHW-1:0]  sh;
  logic                   zsat;
  logic [CW-1:0]          zval;

  logic                   va_r;
  logic [RW-1:0]          na_r;
  logic [SW-1:0]          da_r;
  logic                   nega_r, wza_r, zsata_r;
  logic [CW-1:0]          zvala_r;

  always_comb begin
    smag = in_beat.s[SW-1] ? SW'(-in_beat.s) : SW'(in_beat.s);
    wmag = in_beat.w[SW-1] ? SW'(-in_beat.w) : SW'(in_beat.w);
    sh   = in_beat.s[SW-1:16];
    zsat = !((&sh[SHW-1:CW-1]) || !(|sh[SHW-1:CW-1]));
    if (zsat) begin
      zval = sh[SHW-1] ? ppt_pkg::NEG_MIN : ppt_pkg::POS_MAX;
    end else begin
      zval = sh[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    na_r    <= RW'({smag, 16'h0000});
    da_r    <= wmag;
    nega_r  <= in_beat.s[SW-1] ^ in_beat.w[SW-1];
    wza_r   <= (in_beat.w == '0);
    zsata_r <= zsat;
    zvala_r <= zval;
  end

  // divider chain; index k holds the beat before quotient bit QW-1-k
  logic          vld_r  [QW+1];
  logic [RW-1:0] rem_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [SW-1:0] dvs_r  [QW+1];
  logic          neg_r  [QW+1];
  logic          wz_r   [QW+1];
  logic          zsat_r [QW+1];
  logic [CW-1:0] zval_r [QW+1];
  logic          ovf_r  [QW+1];

  // quotient of 2^32 or more can only saturate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= na_r;
    quo_r[0]  <= '0;
    dvs_r[0]  <= da_r;
    neg_r[0]  <= nega_r;
    wz_r[0]   <= wza_r;
    zsat_r[0] <= zsata_r;
    zval_r[0] <= zvala_r;
    ovf_r[0]  <= (na_r >= {da_r, {QW{1'b0}}});
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(dvs_r[k]) << BIT;
    assign ge  = (rem_r[k] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? (rem_r[k] - dsh) : rem_r[k];
      quo_r[k+1]  <= quo_r[k] | (QW'(ge) << BIT);
      dvs_r[k+1]  <= dvs_r[k];
      neg_r[k+1]  <= neg_r[k];
      wz_r[k+1]   <= wz_r[k];
      zsat_r[k+1] <= zsat_r[k];
      zval_r[k+1] <= zval_r[k];
      ovf_r[k+1]  <= ovf_r[k];
    end
  end

  // sign and clamp
  logic [CW-1:0] q_val;
  logic          q_sat;
  logic [QW-1:0] q;

  always_comb begin
    q = quo_r[QW];
    if (wz_r[QW]) begin
      q_sat = zsat_r[QW];
      q_val = zval_r[QW];
    end else if (!neg_r[QW]) begin
      q_sat = ovf_r[QW] || q[QW-1];
      q_val = q_sat ? ppt_pkg::POS_MAX : CW'(q);
    end else begin
      q_sat = ovf_r[QW] || (q > ppt_pkg::NEG_MIN);
      q_val = q_sat ? ppt_pkg::NEG_MIN : CW'(-q);
    end
  end

  ppt_pkg::comp_beat_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r.valid <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_r.value <= q_val;
    out_r.sat   <= q_sat;
    out_r.wzero <= wz_r[QW];
  end

  assign out_beat = out_r;

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[QW] && ovf_r[QW] && !wz_r[QW]) |=> (out_r.valid && out_r.sat))
    else $error("divide overflow not flagged as saturated");

endmodule

### sv/perspective_point_transform_top.sv
// Top level: configuration registers, matrix sums and three divider lanes.
// Depends on ppt_pkg, ppt_sum and ppt_div.
//
// Takes one point per clock: a start beat is accepted whenever busy is low, which is every
// cycle once reset is over. Each result comes out on out_valid/out_data after the multiply and
// add registers, then the divider lanes' setup, range-check, quotient-bit and result stages,
// whose depth is set by one quotient bit per stage over 32 bits. The receiver cannot stall, so
// each result is shown on out_valid for a single cycle. Matrix registers are written on the cfg
// channel, which is always ready; write them only while no point is in flight.
module perspective_point_transform_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  ppt_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  output ppt_pkg::out_item_t                    out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ppt_pkg::REG_W-1:0]             cfg_data
);

  localparam int IW = $clog2(ppt_pkg::NUM_REGS);

  logic [ppt_pkg::REG_W-1:0] cfg_r [ppt_pkg::NUM_REGS];
  logic                      live_r;
  ppt_pkg::matrix_t          mat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      for (int i = 0; i < ppt_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= ppt_pkg::REG_RESET[i];
      end
    end else begin
      live_r <= 1'b1;
      if (cfg_valid && cfg_ready && (cfg_index < ppt_pkg::CFG_IDX_W'(ppt_pkg::NUM_REGS))) begin
        cfg_r[cfg_index[IW-1:0]] <= cfg_data;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ppt_pkg::NUM_REGS; i++) begin
      mat[i] = cfg_r[i];
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = !live_r;

  ppt_pkg::sums_t sums;

  ppt_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_data),
    .mat      (mat),
    .sums     (sums)
  );

  ppt_pkg::sum_beat_t  bx, by, bz;
  ppt_pkg::comp_beat_t cx, cy, cz;

  assign bx = '{valid: sums.valid, s: sums.sx, w: sums.sw};
  assign by = '{valid: sums.valid, s: sums.sy, w: sums.sw};
  assign bz = '{valid: sums.valid, s: sums.sz, w: sums.sw};

  ppt_div u_div_x (.clk(clk), .rst_n(rst_n), .in_beat(bx), .out_beat(cx));
  ppt_div u_div_y (.clk(clk), .rst_n(rst_n), .in_beat(by), .out_beat(cy));
  ppt_div u_div_z (.clk(clk), .rst_n(rst_n), .in_beat(bz), .out_beat(cz));

  assign out_valid           = cx.valid;
  assign out_data.out_x      = cx.value;
  assign out_data.out_y      = cy.value;
  assign out_data.out_z      = cz.value;
  assign out_data.w_was_zero = cx.wzero;
  assign out_data.saturated  = cx.sat || cy.sat || cz.sat;

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(ppt_pkg::LATENCY) out_valid)
    else $error("accepted point produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ppt_pkg::LATENCY))
    else $error("result beat without a matching start");

  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (cx.valid == cy.valid) && (cx.valid == cz.valid))
    else $error("divider lanes out of step");

endmodule
